// ===== rtl/pkcs1_padding_verify_core_assert.svh =====
// Assertion macros used by the port checker of the padding verifier.
`ifndef PKCS1_PADDING_VERIFY_CORE_ASSERT_SVH
`define PKCS1_PADDING_VERIFY_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PKV_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pkcs1pv check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PKV_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pkcs1pv check failed");

`endif

// ===== rtl/pkcs1pv_pkg.sv =====
// Types, codes and constants of the PKCS#1 v1.5 padding verifier.
`timescale 1ns / 1ps
package pkcs1pv_pkg;

  localparam int POS_W             = 10;
  localparam int DIGEST_BYTES      = 16;
  localparam int DIGEST_IDX_W      = 4;
  localparam int PREFIX_BYTES      = 18;
  localparam int MIN_LENGTH        = PREFIX_BYTES + DIGEST_BYTES + 2;
  localparam int MAX_MESSAGE_BYTES = 512;

  localparam logic [1:0] CMD_LOAD_EXPECTED = 2'd0;
  localparam logic [1:0] CMD_LOAD_IDENTITY = 2'd1;
  localparam logic [1:0] CMD_MESSAGE       = 2'd2;

  localparam logic [1:0] STATUS_CORRECT   = 2'd0;
  localparam logic [1:0] STATUS_IDENTITY  = 2'd1;
  localparam logic [1:0] STATUS_INCORRECT = 2'd2;
  localparam logic [1:0] STATUS_SHORT     = 2'd3;

  typedef struct packed {
    logic                    layout_bad;
    logic                    digest_sel;
    logic [DIGEST_IDX_W-1:0] digest_idx;
    logic                    too_short;
    logic                    count_bad;
  } byte_chk_t;

  function automatic logic [7:0] prefix_byte(input logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'h30;
      5'd1:    b = 8'h20;
      5'd2:    b = 8'h30;
      5'd3:    b = 8'h0c;
      5'd4:    b = 8'h06;
      5'd5:    b = 8'h08;
      5'd6:    b = 8'h2a;
      5'd7:    b = 8'h86;
      5'd8:    b = 8'h48;
      5'd9:    b = 8'h86;
      5'd10:   b = 8'hf7;
      5'd11:   b = 8'h0d;
      5'd12:   b = 8'h02;
      5'd13:   b = 8'h05;
      5'd14:   b = 8'h05;
      5'd15:   b = 8'h00;
      5'd16:   b = 8'h04;
      5'd17:   b = 8'h10;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/pkcs1pv_hash_ram.sv =====
// Digest store: 16 bytes, one write port and one registered read port.
`timescale 1ns / 1ps
module pkcs1pv_hash_ram (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [pkcs1pv_pkg::DIGEST_IDX_W-1:0] waddr_i,
  input  logic [7:0]                           wdata_i,
  input  logic                                 re_i,
  input  logic [pkcs1pv_pkg::DIGEST_IDX_W-1:0] raddr_i,
  output logic [7:0]                           rdata_o
);

  logic [7:0] mem [pkcs1pv_pkg::DIGEST_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pkcs1pv_byte_check.sv =====
// Classifies one message byte by its position, checks the padding and prefix bytes and the length.
`timescale 1ns / 1ps
module pkcs1pv_byte_check (
  input  logic [pkcs1pv_pkg::POS_W-1:0] pos_i,
  input  logic [pkcs1pv_pkg::POS_W-1:0] len_i,
  input  logic [7:0]                    data_i,
  output pkcs1pv_pkg::byte_chk_t        chk_o
);

  localparam int PW = pkcs1pv_pkg::POS_W;

  logic          in_range;
  logic [PW-1:0] end_pos;
  logic [PW-1:0] prefix_off;
  logic [PW-1:0] digest_off;
  logic [PW:0]   received;
  logic          is_first;
  logic          is_run;
  logic          is_end;
  logic          is_prefix;

  always_comb begin
    in_range   = (len_i >= PW'(pkcs1pv_pkg::MIN_LENGTH)) && (pos_i < len_i);
    end_pos    = len_i - PW'(pkcs1pv_pkg::MIN_LENGTH - 1);
    prefix_off = pos_i - end_pos - PW'(1);
    digest_off = pos_i - len_i;
    is_first   = (pos_i == '0);
    is_run     = !is_first && (pos_i < end_pos);
    is_end     = !is_first && (pos_i == end_pos);
    is_prefix  = !is_first && (pos_i > end_pos)
                 && (pos_i <= end_pos + PW'(pkcs1pv_pkg::PREFIX_BYTES));
    received   = {1'b0, pos_i} + (PW+1)'(1);

    chk_o.layout_bad = 1'b0;
    if (in_range) begin
      if (is_first) begin
        chk_o.layout_bad = (data_i != 8'h01);
      end else if (is_run) begin
        chk_o.layout_bad = (data_i != 8'hff);
      end else if (is_end) begin
        chk_o.layout_bad = (data_i != 8'h00);
      end else if (is_prefix) begin
        chk_o.layout_bad = (data_i != pkcs1pv_pkg::prefix_byte(prefix_off[4:0]));
      end
    end
    chk_o.digest_sel = in_range && !is_first && !is_run && !is_end && !is_prefix;
    chk_o.digest_idx = digest_off[pkcs1pv_pkg::DIGEST_IDX_W-1:0];
    chk_o.too_short  = (len_i < PW'(pkcs1pv_pkg::MIN_LENGTH));
    chk_o.count_bad  = (received != {1'b0, len_i})
                       || ({1'b0, len_i} > (PW+1)'(pkcs1pv_pkg::MAX_MESSAGE_BYTES));
  end

endmodule

// ===== rtl/pkcs1_padding_verify_core.sv =====
// Top level of the PKCS#1 v1.5 MD5 signature padding verifier.
//
//   Channel  Direction  Handshake               Payload
//   input    in         in_valid_i/in_ready_o   command_i index_i data_i em_length_i last_i
//   output   out        out_valid_o/out_ready_i status_o
//
// One item is taken per cycle while in_ready_o is high. A load writes a digest store
// at the transfer edge. A message byte reads the digest stores at the transfer edge;
// the compare stage checks it as it advances and registers the flags and the final status.
// Reset clears the byte counter and all valid state, sets the flags; stores keep no reset.
// Input stalls only while the compare stage holds a last byte and a status waits unread.
`timescale 1ns / 1ps
module pkcs1_padding_verify_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           command_i,
  input  logic [pkcs1pv_pkg::DIGEST_IDX_W-1:0] index_i,
  input  logic [7:0]                           data_i,
  input  logic [pkcs1pv_pkg::POS_W-1:0]        em_length_i,
  input  logic                                 last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           status_o
);

  localparam int PW = pkcs1pv_pkg::POS_W;

  logic                   in_xfer;
  logic                   msg_xfer;
  logic                   advance;
  logic                   s1_done;
  logic                   s1_final;
  pkcs1pv_pkg::byte_chk_t chk;
  logic [7:0]             exp_rd;
  logic [7:0]             id_rd;
  logic                   lay_ok;
  logic                   hash_eq;
  logic                   id_eq;
  logic [1:0]             verdict;

  logic [PW-1:0]          pos_q, pos_d;
  logic                   s1_valid_q;
  pkcs1pv_pkg::byte_chk_t s1_chk_q;
  logic [7:0]             s1_data_q;
  logic                   s1_last_q;
  logic                   layout_ok_q, hash_equal_q, identity_equal_q;
  logic                   out_valid_q;
  logic [1:0]             status_q;

  assign s1_final   = s1_valid_q && s1_last_q;
  assign advance    = !(s1_final && out_valid_q && !out_ready_i);
  assign in_ready_o = advance;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign msg_xfer   = in_xfer && (command_i == pkcs1pv_pkg::CMD_MESSAGE);
  assign s1_done    = s1_valid_q && advance;

  pkcs1pv_byte_check u_check (
    .pos_i  (pos_q),
    .len_i  (em_length_i),
    .data_i (data_i),
    .chk_o  (chk)
  );

  pkcs1pv_hash_ram u_expected (
    .clk_i   (clk_i),
    .we_i    (in_xfer && (command_i == pkcs1pv_pkg::CMD_LOAD_EXPECTED)),
    .waddr_i (index_i),
    .wdata_i (data_i),
    .re_i    (msg_xfer && chk.digest_sel),
    .raddr_i (chk.digest_idx),
    .rdata_o (exp_rd)
  );

  pkcs1pv_hash_ram u_identity (
    .clk_i   (clk_i),
    .we_i    (in_xfer && (command_i == pkcs1pv_pkg::CMD_LOAD_IDENTITY)),
    .waddr_i (index_i),
    .wdata_i (data_i),
    .re_i    (msg_xfer && chk.digest_sel),
    .raddr_i (chk.digest_idx),
    .rdata_o (id_rd)
  );

  always_comb begin
    pos_d = pos_q;
    if (msg_xfer) begin
      if (last_i) begin
        pos_d = '0;
      end else if (pos_q != {PW{1'b1}}) begin
        pos_d = pos_q + PW'(1);
      end
    end
  end

  always_comb begin
    lay_ok  = layout_ok_q && !s1_chk_q.layout_bad;
    hash_eq = hash_equal_q && !(s1_chk_q.digest_sel && (s1_data_q != exp_rd));
    id_eq   = identity_equal_q && !(s1_chk_q.digest_sel && (s1_data_q != id_rd));
    if (s1_chk_q.too_short) begin
      verdict = pkcs1pv_pkg::STATUS_SHORT;
    end else if (s1_chk_q.count_bad || !lay_ok) begin
      verdict = pkcs1pv_pkg::STATUS_INCORRECT;
    end else if (hash_eq) begin
      verdict = pkcs1pv_pkg::STATUS_CORRECT;
    end else if (id_eq) begin
      verdict = pkcs1pv_pkg::STATUS_IDENTITY;
    end else begin
      verdict = pkcs1pv_pkg::STATUS_INCORRECT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q            <= '0;
      s1_valid_q       <= 1'b0;
      layout_ok_q      <= 1'b1;
      hash_equal_q     <= 1'b1;
      identity_equal_q <= 1'b1;
      out_valid_q      <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (advance) begin
        s1_valid_q <= msg_xfer;
      end
      if (s1_done) begin
        if (s1_last_q) begin
          layout_ok_q      <= 1'b1;
          hash_equal_q     <= 1'b1;
          identity_equal_q <= 1'b1;
        end else begin
          layout_ok_q      <= lay_ok;
          hash_equal_q     <= hash_eq;
          identity_equal_q <= id_eq;
        end
      end
      if (s1_done && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (msg_xfer) begin
      s1_chk_q  <= chk;
      s1_data_q <= data_i;
      s1_last_q <= last_i;
    end
    if (s1_done && s1_last_q) begin
      status_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule

// ===== rtl/pkcs1pv_port_check.sv =====
// Port-level checker for the padding verifier, bound to the top level.
`timescale 1ns / 1ps
`include "pkcs1_padding_verify_core_assert.svh"
module pkcs1pv_port_check (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic [1:0]                           command_i,
  input logic                                 last_i,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic [1:0]                           status_o
);

  `PKV_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o))
  `PKV_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)
  `PKV_ASSERT_NOW(a_result_source, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && in_ready_o && last_i && (command_i == pkcs1pv_pkg::CMD_MESSAGE), 2))

endmodule

bind pkcs1_padding_verify_core pkcs1pv_port_check u_port_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .command_i   (command_i),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o)
);
